### src/pel_pkg.sv
// Shared types and constants for the positional list engine.
`default_nettype none
package pel_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W = 14;
  localparam int unsigned CAPACITY_DEF = 128;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_GET    = 3'd2,
    ACT_LOCATE = 3'd3,
    ACT_CLEAR  = 3'd4
  } pel_action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } pel_status_e;

  typedef struct packed {
    logic              up;
    logic              dn;
    logic              locate;
    logic [POS_W-1:0]  p0;
    logic [POS_W-1:0]  lim;
    logic [DATA_W-1:0] key;
  } pel_ctl_t;

  typedef struct packed {
    logic              hit;
    logic [POS_W-1:0]  idx;
    logic [DATA_W-1:0] val;
  } pel_node_t;

endpackage
`default_nettype wire

### src/pel_cell.sv
// One list cell: holds an entry, shifts with its neighbors and flags a match.
`default_nettype none
module pel_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire pel_pkg::pel_ctl_t           ctl_i,
  input  wire logic [pel_pkg::DATA_W-1:0]  left_i,
  input  wire logic [pel_pkg::DATA_W-1:0]  right_i,
  output logic      [pel_pkg::DATA_W-1:0]  entry_o,
  output pel_pkg::pel_node_t               leaf_o
);

  localparam logic [pel_pkg::POS_W-1:0] MyIdx = pel_pkg::POS_W'(IDX);

  logic [pel_pkg::DATA_W-1:0] entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (en_i && ctl_i.up) begin
      if (MyIdx > ctl_i.p0) begin
        entry_d = left_i;
      end else if (MyIdx == ctl_i.p0) begin
        entry_d = ctl_i.key;
      end
    end else if (en_i && ctl_i.dn && (MyIdx >= ctl_i.p0)) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o    = entry_q;
  assign leaf_o.hit = (MyIdx < ctl_i.lim) &&
                      (ctl_i.locate ? (entry_q == ctl_i.key) : (MyIdx == ctl_i.p0));
  assign leaf_o.idx = MyIdx;
  assign leaf_o.val = entry_q;

endmodule
`default_nettype wire

### src/pel_tree.sv
// Registered priority tree that picks the lowest flagged cell.
`default_nettype none
module pel_tree #(
  parameter int unsigned CAPACITY = pel_pkg::CAPACITY_DEF
) (
  input  wire logic        clk_i,
  input  pel_pkg::pel_node_t leaf_i [CAPACITY],
  output pel_pkg::pel_node_t root_o
);

  localparam int unsigned Levels = $clog2(CAPACITY);
  localparam int unsigned NumLeaf = 1 << Levels;

  pel_pkg::pel_node_t node_q [1:2*NumLeaf-1];

  for (genvar j = 0; j < NumLeaf; j++) begin : g_leaf
    if (j < CAPACITY) begin : g_used
      always_ff @(posedge clk_i) begin
        node_q[NumLeaf+j] <= leaf_i[j];
      end
    end else begin : g_pad
      always_ff @(posedge clk_i) begin
        node_q[NumLeaf+j] <= '0;
      end
    end
  end

  for (genvar i = 1; i < NumLeaf; i++) begin : g_node
    always_ff @(posedge clk_i) begin
      node_q[i] <= node_q[2*i].hit ? node_q[2*i] : node_q[2*i+1];
    end
  end

  assign root_o = node_q[1];

endmodule
`default_nettype wire

### src/positional_list_engine_unit.sv
// Top level of the positional list engine: control, cell row, tree and output word.
// Each word is accepted in the idle state; the scan state then waits for the registered
// priority tree to settle on the lowest matching cell, and the done state shifts the
// cell row and loads the result once the output register is free. No new word is
// accepted before the done state ends. A finished result waits in the output
// register while the next word is taken in.
`default_nettype none
module positional_list_engine_unit #(
  parameter int unsigned CAPACITY = pel_pkg::CAPACITY_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  action_i,
  input  wire logic [7:0]  position_i,
  input  wire logic [31:0] item_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [31:0]      read_value_o,
  output logic [7:0]       found_position_o,
  output logic [7:0]       list_length_o
);

  localparam int unsigned Levels = $clog2(CAPACITY);
  localparam int unsigned WaitW = $clog2(Levels + 1);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [pel_pkg::POS_W-1:0] CapPos = pel_pkg::POS_W'(CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                 state_q, state_d;
  logic [WaitW-1:0]           wait_q, wait_d;
  logic [CntW-1:0]            count_q, count_d;
  logic [2:0]                 act_q;
  logic [7:0]                 pos_q;
  logic [31:0]                val_q;
  logic                       ovalid_q, ovalid_d;
  logic [1:0]                 status_q, status_d;
  logic [31:0]                rdval_q, rdval_d;
  logic [7:0]                 found_q, found_d;
  logic [7:0]                 len_q, len_d;

  logic                       in_fire, done_fire, range_ok, is_full;
  logic [pel_pkg::POS_W-1:0]  pos_w, cnt_w;
  pel_pkg::pel_ctl_t          ctl;
  pel_pkg::pel_node_t         root;
  pel_pkg::pel_node_t         leaf [CAPACITY];
  logic [31:0]                entry [CAPACITY];

  assign in_fire   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign done_fire = (state_q == S_DONE) && (!ovalid_q || !out_stall_i);

  assign pos_w = pel_pkg::POS_W'(pos_q);
  assign cnt_w = pel_pkg::POS_W'(count_q);
  assign is_full = (cnt_w == CapPos);

  always_comb begin
    range_ok = 1'b0;
    case (act_q) inside
      pel_pkg::ACT_INSERT: range_ok = (pos_w != '0) && (pos_w <= cnt_w + 1'b1);
      pel_pkg::ACT_DELETE, pel_pkg::ACT_GET: range_ok = (pos_w != '0) && (pos_w <= cnt_w);
      default: range_ok = 1'b0;
    endcase
  end

  always_comb begin
    ctl        = '0;
    ctl.p0     = pos_w - 1'b1;
    ctl.lim    = cnt_w;
    ctl.key    = val_q;
    ctl.locate = (act_q == pel_pkg::ACT_LOCATE);
    ctl.up     = (act_q == pel_pkg::ACT_INSERT) && range_ok && !is_full;
    ctl.dn     = (act_q == pel_pkg::ACT_DELETE) && range_ok;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = entry[i+1];
    end
    pel_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i   (clk_i),
      .en_i    (done_fire),
      .ctl_i   (ctl),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entry[i]),
      .leaf_o  (leaf[i])
    );
  end

  pel_tree #(
    .CAPACITY(CAPACITY)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (leaf),
    .root_o (root)
  );

  always_comb begin
    state_d  = state_q;
    wait_d   = wait_q;
    count_d  = count_q;
    ovalid_d = ovalid_q && out_stall_i;
    status_d = status_q;
    rdval_d  = rdval_q;
    found_d  = found_q;
    len_d    = len_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_SCAN;
          wait_d  = WaitW'(Levels);
        end
      end
      S_SCAN: begin
        if (wait_q == '0) begin
          state_d = S_DONE;
        end else begin
          wait_d = wait_q - 1'b1;
        end
      end
      S_DONE: begin
        if (done_fire) begin
          state_d  = S_IDLE;
          ovalid_d = 1'b1;
          status_d = pel_pkg::ST_OK;
          rdval_d  = '0;
          found_d  = '0;
          case (act_q) inside
            pel_pkg::ACT_INSERT: begin
              if (!range_ok) begin
                status_d = pel_pkg::ST_RANGE;
              end else if (is_full) begin
                status_d = pel_pkg::ST_FULL;
              end else begin
                count_d = count_q + 1'b1;
              end
            end
            pel_pkg::ACT_DELETE, pel_pkg::ACT_GET: begin
              if (!range_ok) begin
                status_d = pel_pkg::ST_RANGE;
              end else begin
                rdval_d = root.val;
                if (act_q == pel_pkg::ACT_DELETE) begin
                  count_d = count_q - 1'b1;
                end
              end
            end
            pel_pkg::ACT_LOCATE: begin
              if (root.hit) begin
                found_d = 8'(root.idx + 1'b1);
              end
            end
            pel_pkg::ACT_CLEAR: begin
              count_d = '0;
            end
            default: begin
              count_d = count_q;
            end
          endcase
          len_d = 8'(pel_pkg::POS_W'(count_d));
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      wait_q   <= '0;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      wait_q   <= wait_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q <= action_i;
      pos_q <= position_i;
      val_q <= item_value_i;
    end
    status_q <= status_d;
    rdval_q  <= rdval_d;
    found_q  <= found_d;
    len_q    <= len_d;
  end

  assign out_valid_o      = ovalid_q;
  assign status_o         = status_q;
  assign read_value_o     = rdval_q;
  assign found_position_o = found_q;
  assign list_length_o    = len_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pel_pkg::POS_W'(count_q) <= CapPos)
    else $error("entry count above capacity");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_DONE)
    else $error("result word without a finished scan");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_fire && ctl.up |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the list");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("input taken while a word is in flight");

endmodule
`default_nettype wire

### sim/positional_list_engine_unit_test.sv
// Self-checking bench for the positional list engine: queued words, live list model, scoreboard.
module positional_list_engine_unit_test;
  import pel_pkg::*;

  localparam int LIST_DEPTH = CAPACITY_DEF;
  localparam int RUN_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 30;
  localparam int STRETCH_WORDS = 650;
  localparam logic [2:0] ACT_NOP_A = 3'd5;
  localparam logic [2:0] ACT_NOP_B = 3'd6;
  localparam logic [2:0] ACT_NOP_C = 3'd7;

  typedef struct packed {
    logic [2:0]         action;
    logic [7:0]         position;
    logic signed [31:0] item_value;
  } list_word_t;

  typedef struct packed {
    pel_status_e        status;
    logic signed [31:0] read_value;
    logic [7:0]         found_position;
    logic [7:0]         list_length;
  } list_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic [2:0]  action_i = '0;
  logic [7:0]  position_i = '0;
  logic [31:0] item_value_i = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  status_o;
  logic [31:0] read_value_o;
  logic [7:0]  found_position_o;
  logic [7:0]  list_length_o;

  list_word_t  pending_words[$];
  list_reply_t expected_replies[$];
  list_word_t  drv_word;

  logic signed [31:0] list_cells [LIST_DEPTH];
  int list_len = 0;
  int gen_len = 0;
  int queued_total = 0;
  logic [31:0] value_pool [16];

  int send_gap_pct = 0;
  int recv_hold_pct = 0;
  int errors = 0;
  int cycle_count = 0;
  int words_seen = 0;
  int status_tally [3] = '{0, 0, 0};
  int locate_hits = 0;
  int full_reached = 0;

  positional_list_engine_unit #(.CAPACITY(LIST_DEPTH)) dut (.*);

  always #2 clk_i = ~clk_i;

  function automatic list_reply_t step_list(input list_word_t w);
    list_reply_t r;
    int p;
    r = '0;
    r.status = ST_OK;
    p = w.position;
    case (w.action)
      ACT_INSERT: begin
        if (p < 1 || p > list_len + 1) begin
          r.status = ST_RANGE;
        end else if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int k = list_len; k > p - 1; k--) list_cells[k] = list_cells[k - 1];
          list_cells[p - 1] = w.item_value;
          list_len++;
          if (list_len == LIST_DEPTH) full_reached++;
        end
      end
      ACT_DELETE, ACT_GET: begin
        if (p < 1 || p > list_len) begin
          r.status = ST_RANGE;
        end else begin
          r.read_value = list_cells[p - 1];
          if (w.action == ACT_DELETE) begin
            for (int k = p; k < list_len; k++) list_cells[k - 1] = list_cells[k];
            list_len--;
          end
        end
      end
      ACT_LOCATE: begin
        for (int k = 0; k < list_len && r.found_position == 0; k++)
          if (list_cells[k] == w.item_value) r.found_position = 8'(k + 1);
        if (r.found_position != 0) locate_hits++;
      end
      ACT_CLEAR: begin
        list_len = 0;
      end
      default: begin
      end
    endcase
    r.list_length = 8'(list_len);
    status_tally[r.status]++;
    return r;
  endfunction

  task automatic queue_word(input logic [2:0] act, input int pos, input logic [31:0] val);
    list_word_t w;
    w.action = act;
    w.position = 8'(pos);
    w.item_value = val;
    pending_words.push_back(w);
    queued_total++;
    if (act == ACT_INSERT && pos >= 1 && pos <= gen_len + 1 && gen_len < LIST_DEPTH)
      gen_len++;
    else if (act == ACT_DELETE && pos >= 1 && pos <= gen_len)
      gen_len--;
    else if (act == ACT_CLEAR)
      gen_len = 0;
  endtask

  function automatic int pick_pos(input int lo, input int hi);
    return (hi >= lo) ? $urandom_range(hi, lo) : 0;
  endfunction

  function automatic logic [31:0] pick_value();
    return ($urandom_range(9) < 6) ? value_pool[$urandom_range(15)] : $urandom();
  endfunction

  function automatic int bad_pos(input int first_bad);
    int r;
    r = $urandom_range(2);
    return (r == 0) ? 0 : (r == 1) ? first_bad : $urandom_range(255);
  endfunction

  task automatic directed_words();
    queue_word(ACT_GET, 1, 32'd0);
    queue_word(ACT_DELETE, 0, 32'd0);
    queue_word(ACT_INSERT, 0, 32'h1111_1111);
    queue_word(ACT_INSERT, 2, 32'h2222_2222);
    queue_word(ACT_INSERT, 1, 32'h8000_0000);
    queue_word(ACT_INSERT, 2, 32'h7FFF_FFFF);
    queue_word(ACT_INSERT, 1, 32'hFFFF_FFFF);
    queue_word(ACT_INSERT, 4, 32'h0000_0000);
    queue_word(ACT_INSERT, 3, 32'h7FFF_FFFF);
    queue_word(ACT_GET, 1, 32'd0);
    queue_word(ACT_GET, 5, 32'd0);
    queue_word(ACT_GET, 6, 32'd0);
    queue_word(ACT_LOCATE, 0, 32'h7FFF_FFFF);
    queue_word(ACT_LOCATE, 0, 32'h1234_5678);
    queue_word(ACT_LOCATE, 0, 32'h0000_0000);
    queue_word(ACT_DELETE, 5, 32'd0);
    queue_word(ACT_DELETE, 1, 32'd0);
    queue_word(ACT_GET, 255, 32'd0);
    queue_word(ACT_INSERT, 255, 32'h5555_AAAA);
    queue_word(ACT_NOP_A, 1, 32'hFFFF_FFFF);
    queue_word(ACT_NOP_B, 2, 32'd0);
    queue_word(ACT_NOP_C, 255, 32'hAAAA_5555);
    queue_word(ACT_CLEAR, 0, 32'd0);
    queue_word(ACT_GET, 1, 32'd0);
    queue_word(ACT_LOCATE, 0, 32'h8000_0000);
  endtask

  task automatic random_stretch(input int count);
    int target;
    int kind;
    int r;
    int n;
    bit first;
    target = queued_total + count;
    first = 1'b1;
    while (queued_total < target) begin
      kind = first ? 0 : $urandom_range(99);
      first = 1'b0;
      if (kind < 20) begin
        while (gen_len < LIST_DEPTH) begin
          if ($urandom_range(5) == 0) queue_word(ACT_LOCATE, 0, pick_value());
          else queue_word(ACT_INSERT, pick_pos(1, gen_len + 1), pick_value());
        end
        repeat ($urandom_range(3, 1)) queue_word(ACT_INSERT, pick_pos(1, LIST_DEPTH + 1),
                                                 pick_value());
        queue_word(ACT_INSERT, LIST_DEPTH + 2, pick_value());
        queue_word(ACT_GET, LIST_DEPTH, 32'd0);
        queue_word(ACT_DELETE, LIST_DEPTH + 1, 32'd0);
      end else if (kind < 40) begin
        n = $urandom_range(gen_len);
        repeat (n) begin
          if ($urandom_range(3) == 0) queue_word(ACT_LOCATE, 0, pick_value());
          if (gen_len > 0) queue_word(ACT_DELETE, pick_pos(1, gen_len), 32'd0);
        end
      end else if (kind < 80) begin
        repeat (20) begin
          r = $urandom_range(99);
          if (r < 35) begin
            queue_word(ACT_INSERT, ($urandom_range(99) < 85) ? pick_pos(1, gen_len + 1)
                                                             : bad_pos(gen_len + 2),
                       pick_value());
          end else if (r < 75) begin
            queue_word((r < 55) ? ACT_DELETE : ACT_GET,
                       ($urandom_range(99) < 85 && gen_len > 0) ? pick_pos(1, gen_len)
                                                                 : bad_pos(gen_len + 1),
                       $urandom());
          end else if (r < 95) begin
            queue_word(ACT_LOCATE, $urandom_range(255), pick_value());
          end else if (r < 97) begin
            queue_word(ACT_CLEAR, $urandom_range(255), $urandom());
          end else begin
            queue_word(3'(ACT_NOP_A + $urandom_range(2)), $urandom_range(255), $urandom());
          end
        end
      end else if (kind < 95) begin
        repeat (10) queue_word(3'($urandom_range(7)), $urandom_range(255), $urandom());
      end else begin
        queue_word(ACT_CLEAR, 0, 32'd0);
        queue_word(ACT_GET, pick_pos(0, 2), 32'd0);
        queue_word(ACT_INSERT, pick_pos(1, 2), pick_value());
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || expected_replies.size() != 0);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) expected_replies.push_back(step_list(drv_word));
      if (!in_valid_i || !in_stall_o) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          drv_word = pending_words.pop_front();
          in_valid_i <= 1'b1;
          action_i <= drv_word.action;
          position_i <= drv_word.position;
          item_value_i <= drv_word.item_value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    list_reply_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        words_seen++;
        if (expected_replies.size() == 0) begin
          $error("unexpected result word: status %0d list_length %0d", status_o, list_length_o);
          errors++;
        end else begin
          want = expected_replies.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            errors++;
          end
          if (read_value_o !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, $signed(read_value_o));
            errors++;
          end
          if (found_position_o !== want.found_position) begin
            $error("found_position: expected %0d, got %0d", want.found_position,
                   found_position_o);
            errors++;
          end
          if (list_length_o !== want.list_length) begin
            $error("list_length: expected %0d, got %0d", want.list_length, list_length_o);
            errors++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_hold_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'h8000_0000;
    value_pool[2] = 32'h7FFF_FFFF;
    value_pool[3] = 32'hFFFF_FFFF;
    for (int k = 4; k < 16; k++) value_pool[k] = $urandom();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    directed_words();
    wait_drained();
    send_gap_pct = 17;
    recv_hold_pct = 70;
    random_stretch(STRETCH_WORDS);
    wait_drained();
    send_gap_pct = 70;
    recv_hold_pct = 17;
    random_stretch(STRETCH_WORDS);
    wait_drained();
    send_gap_pct = 0;
    recv_hold_pct = 0;
    random_stretch(STRETCH_WORDS);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Checked %0d result words in %0d cycles: %0d ok, %0d out of range, %0d list full.",
             words_seen, cycle_count, status_tally[ST_OK], status_tally[ST_RANGE],
             status_tally[ST_FULL]);
    $display("List filled to capacity %0d times; %0d locates found a match.",
             full_reached, locate_hits);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
